// ----- rtl/swp_pkg.sv -----
// ----------------------------------------------------------------------------
// swp_pkg
// Widths, reset values and types shared by the stream width packer.
// ----------------------------------------------------------------------------
`default_nettype none

package swp_pkg;

	localparam int BEAT_W   = 64;
	localparam int ACC_W    = 8;
	localparam int CNT_W    = 25;
	localparam int PBITS_W  = 7;
	localparam int KEEP_W   = 8;
	localparam int TOTAL_W  = 8;
	localparam int NBYTES_W = 4;
	localparam int COMB_W   = BEAT_W + ACC_W;

	localparam logic [CNT_W-1:0] FRAME_BITS_RST = CNT_W'(1024);

	typedef logic [BEAT_W-1:0]  beat_t;
	typedef logic [ACC_W-1:0]   acc_t;
	typedef logic [CNT_W-1:0]   cnt_t;
	typedef logic [PBITS_W-1:0] pbits_t;
	typedef logic [KEEP_W-1:0]  keep_t;

endpackage

`default_nettype wire

// ----- rtl/stream_width_packer.sv -----
// ----------------------------------------------------------------------------
// stream_width_packer
// Packs narrow accelerator words into wide stream beats with byte keep and
// frame last flag.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake               Payload
// acc       in         acc_valid / acc_ready   acc_word
// beat      out        beat_valid / beat_ready beat_data, beat_keep, beat_last
// cfg       in         cfg_valid / cfg_ready   frame_bits
//
// A word is registered in the input register on acceptance and packed into the
// beat register once that has space; the beat is presented from that register.
// One word is taken per cycle unless the beat output stalls; the packing step
// between the input register and the beat register sets that rate.
// The input register holds one word while a finished beat waits to be taken.
// Reset clears the pending bits, the frame counter and frame_bits to 1024.
// ----------------------------------------------------------------------------
`default_nettype none

module stream_width_packer
	import swp_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  acc_valid,
	output logic       acc_ready,
	input  wire acc_t  acc_word,
	output logic       beat_valid,
	input  wire logic  beat_ready,
	output beat_t      beat_data,
	output keep_t      beat_keep,
	output logic       beat_last,
	input  wire logic  cfg_valid,
	output logic       cfg_ready,
	input  wire cnt_t  frame_bits
);

	logic   valid_s1;
	acc_t   acc_word_s1;
	cnt_t   frame_bits_q;
	beat_t  pending_word_q;
	pbits_t pending_bits_q;
	cnt_t   frame_cnt_q;
	logic   beat_valid_q;
	beat_t  beat_data_q;
	keep_t  beat_keep_q;
	logic   beat_last_q;

	logic                 out_space;
	logic                 advance;
	pbits_t               p_sat;
	beat_t                pmask;
	logic [COMB_W-1:0]    comb;
	logic [TOTAL_W-1:0]   total;
	logic [TOTAL_W-1:0]   left;
	cnt_t                 frame_cnt_next;
	logic                 frame_end;
	logic                 emit;
	logic [NBYTES_W-1:0]  nbytes;
	keep_t                keep;
	pbits_t               pending_bits_emit;

	function automatic beat_t low_mask(input pbits_t n);
		beat_t m;
		if (n >= PBITS_W'(BEAT_W)) begin
			m = '1;
		end else begin
			m = (beat_t'(1) << n) - beat_t'(1);
		end
		return m;
	endfunction

	assign out_space = !beat_valid_q || beat_ready;
	assign advance   = valid_s1 && out_space;
	assign acc_ready = !valid_s1 || advance;
	assign cfg_ready = 1'b1;

	always_comb begin
		p_sat = (pending_bits_q > PBITS_W'(BEAT_W)) ? PBITS_W'(BEAT_W) : pending_bits_q;
		pmask = low_mask(p_sat);
		comb  = {ACC_W'(0), pending_word_q & pmask} | ({BEAT_W'(0), acc_word_s1} << p_sat);
		total = TOTAL_W'(p_sat) + TOTAL_W'(ACC_W);
		left  = total - TOTAL_W'(BEAT_W);

		frame_cnt_next = frame_cnt_q + CNT_W'(ACC_W);
		frame_end      = frame_cnt_next >= frame_bits_q;
		emit           = (total >= TOTAL_W'(BEAT_W)) || frame_end;

		if ((total >> 3) > TOTAL_W'(KEEP_W)) begin
			nbytes = NBYTES_W'(KEEP_W);
		end else begin
			nbytes = NBYTES_W'(total >> 3);
		end
		keep = KEEP_W'((16'(1) << nbytes) - 16'(1));

		if (total > TOTAL_W'(BEAT_W)) begin
			if (left > TOTAL_W'(BEAT_W)) begin
				pending_bits_emit = PBITS_W'(BEAT_W);
			end else begin
				pending_bits_emit = left[PBITS_W-1:0];
			end
		end else begin
			pending_bits_emit = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (acc_ready) begin
			valid_s1 <= acc_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (acc_valid && acc_ready) begin
			acc_word_s1 <= acc_word;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_bits_q <= FRAME_BITS_RST;
		end else if (cfg_valid && cfg_ready) begin
			frame_bits_q <= frame_bits;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_word_q <= '0;
			pending_bits_q <= '0;
			frame_cnt_q    <= '0;
		end else if (advance) begin
			if (emit) begin
				pending_word_q <= beat_t'(comb[COMB_W-1:BEAT_W]);
				pending_bits_q <= pending_bits_emit;
				frame_cnt_q    <= frame_end ? (frame_cnt_next - frame_bits_q) : frame_cnt_next;
			end else begin
				pending_word_q <= comb[BEAT_W-1:0];
				pending_bits_q <= total[PBITS_W-1:0];
				frame_cnt_q    <= frame_cnt_next;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			beat_valid_q <= 1'b0;
		end else if (out_space) begin
			beat_valid_q <= advance && emit;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && emit) begin
			beat_data_q <= comb[BEAT_W-1:0];
			beat_keep_q <= keep;
			beat_last_q <= frame_end;
		end
	end

	assign beat_valid = beat_valid_q;
	assign beat_data  = beat_data_q;
	assign beat_keep  = beat_keep_q;
	assign beat_last  = beat_last_q;

	a_pending_bound: assert property (@(posedge clk) disable iff (!arst_n)
		pending_bits_q <= PBITS_W'(BEAT_W))
		else $error("Pending bit count exceeds the beat width.");

	a_emit_shows_beat: assert property (@(posedge clk) disable iff (!arst_n)
		advance && emit |=> beat_valid)
		else $error("A packed beat was not presented.");

	a_keep_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		beat_valid |-> beat_keep != '0)
		else $error("A beat carries no valid byte.");

	a_held_word: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !out_space |=> valid_s1 && $stable(acc_word_s1))
		else $error("A registered word was lost while the output stalled.");

	a_idle_no_beat: assert property (@(posedge clk) disable iff (!arst_n)
		!advance && out_space |=> !beat_valid)
		else $error("A beat appeared without a transaction to cause it.");

endmodule

`default_nettype wire
